// ----- hw/rtl/bfha_pkg.sv -----
// Shared types and constants for the best-fit hole allocator.
package bfha_pkg;

  localparam int MAX_HOLES    = 16;
  localparam int SIZE_BITS    = 16;
  localparam int IDX_W        = $clog2(MAX_HOLES);
  localparam int CNT_W        = $clog2(MAX_HOLES + 1);
  localparam int CMD_W        = 2;
  localparam int SIZE_FIELD_W = 16;
  localparam int STATUS_W     = 2;
  localparam int HOLE_INDEX_W = 4;
  localparam int LEFTOVER_W   = 16;

  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_FIT    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [SIZE_BITS-1:0] wr_data;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [HOLE_INDEX_W-1:0] hole_index;
    logic [LEFTOVER_W-1:0]   leftover;
  } result_t;

endpackage

// ----- hw/rtl/bfha_size_mem.sv -----
// Hole size memory: one write port, one read port, registered read data.
module bfha_size_mem (
  input  logic                          clk,
  input  bfha_pkg::mem_req_t            req,
  output logic [bfha_pkg::SIZE_BITS-1:0] rd_data
);
  import bfha_pkg::*;

  logic [SIZE_BITS-1:0] mem [MAX_HOLES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// ----- hw/rtl/bfha_ctrl.sv -----
// Command sequencer: table count, used marks and the best-fit scan.
module bfha_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic [bfha_pkg::CMD_W-1:0]        command,
  input  logic [bfha_pkg::SIZE_FIELD_W-1:0] size,
  output bfha_pkg::mem_req_t                mem_req,
  input  logic [bfha_pkg::SIZE_BITS-1:0]    rd_data,
  output logic                             res_valid,
  input  logic                             res_ready,
  output bfha_pkg::result_t                 res
);
  import bfha_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_MARK   = 2'd2;
  localparam logic [1:0] S_RESULT = 2'd3;

  logic [1:0]           state;
  logic [CNT_W-1:0]     hole_count;
  logic [MAX_HOLES-1:0] hole_used;
  logic [SIZE_BITS-1:0] req_size;
  logic [IDX_W-1:0]     pend_idx;
  logic [CNT_W-1:0]     issue_next;
  logic                 found;
  logic [IDX_W-1:0]     best_idx;
  logic [SIZE_BITS-1:0] best_left;

  logic                 accept;
  logic [SIZE_BITS-1:0] in_size;
  logic                 fits;
  logic [SIZE_BITS-1:0] cur_left;
  logic                 better;
  logic                 more;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && (state == S_IDLE);
  assign in_size    = SIZE_BITS'(size);
  assign res_valid  = (state == S_RESULT);

  assign fits     = !hole_used[pend_idx] && (rd_data >= req_size);
  assign cur_left = rd_data - req_size;
  assign better   = fits && (!found || (cur_left < best_left));
  assign more     = (issue_next < hole_count);

  always_comb begin
    mem_req         = '0;
    mem_req.wr_addr = hole_count[IDX_W-1:0];
    mem_req.wr_data = in_size;
    mem_req.rd_addr = issue_next[IDX_W-1:0];
    if (accept && (command == CMD_ADD) && (hole_count < CNT_W'(MAX_HOLES))) begin
      mem_req.wr_en = 1'b1;
    end
    if (accept && (command == CMD_REQUEST)) begin
      mem_req.rd_en   = 1'b1;
      mem_req.rd_addr = '0;
    end else if ((state == S_SCAN) && more) begin
      mem_req.rd_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      hole_count <= '0;
      hole_used  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (command)
              CMD_CLEAR: begin
                hole_count <= '0;
                hole_used  <= '0;
                res        <= '{ST_DONE, '0, '0};
                state      <= S_RESULT;
              end
              CMD_ADD: begin
                if (hole_count >= CNT_W'(MAX_HOLES)) begin
                  res <= '{ST_FULL, '0, '0};
                end else begin
                  hole_used[hole_count[IDX_W-1:0]] <= 1'b0;
                  hole_count <= hole_count + 1'b1;
                  res <= '{ST_DONE, HOLE_INDEX_W'(hole_count[IDX_W-1:0]), '0};
                end
                state <= S_RESULT;
              end
              CMD_REQUEST: begin
                req_size   <= in_size;
                found      <= 1'b0;
                pend_idx   <= '0;
                issue_next <= CNT_W'(1);
                // first read is already on its way; an empty table skips the scan
                state <= (hole_count == '0) ? S_MARK : S_SCAN;
              end
              default: begin
                res   <= '{ST_DONE, '0, '0};
                state <= S_RESULT;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (better) begin
            found     <= 1'b1;
            best_idx  <= pend_idx;
            best_left <= cur_left;
          end
          if (more) begin
            pend_idx   <= issue_next[IDX_W-1:0];
            issue_next <= issue_next + 1'b1;
          end else begin
            state <= S_MARK;
          end
        end
        S_MARK: begin
          if (found) begin
            hole_used[best_idx] <= 1'b1;
            res <= '{ST_ALLOCATED, HOLE_INDEX_W'(best_idx), LEFTOVER_W'(best_left)};
          end else begin
            res <= '{ST_NO_FIT, '0, '0};
          end
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/best_fit_hole_allocator.sv -----
// Best-fit hole allocator top level: sequencer, size memory and output register.
//
// Keeps a table of up to 16 holes (16-bit sizes) in a one-port-read,
// one-port-write synchronous memory, with used marks and the hole count in
// flip-flops. Commands: clear (0), add (1), request (2); code 3 changes no state
// and just returns done. One item is worked on at a time. A request first
// scans the table, reading one memory entry per cycle through the single
// read port, then marks the chosen hole and hands the result to the output
// register. The output register lets the next item be accepted while a result
// still waits to be taken.
module best_fit_hole_allocator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic [bfha_pkg::CMD_W-1:0]        command,
  input  logic [bfha_pkg::SIZE_FIELD_W-1:0] size,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [bfha_pkg::STATUS_W-1:0]     status,
  output logic [bfha_pkg::HOLE_INDEX_W-1:0] hole_index,
  output logic [bfha_pkg::LEFTOVER_W-1:0]   leftover
);
  import bfha_pkg::*;

  mem_req_t             mem_req;
  logic [SIZE_BITS-1:0] rd_data;
  logic                 res_valid;
  logic                 res_ready;
  result_t              res;
  result_t              out_reg;

  bfha_size_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  bfha_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .command    (command),
    .size       (size),
    .mem_req    (mem_req),
    .rd_data    (rd_data),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // load the output register when it is empty or being drained
  assign res_ready = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_ready) begin
      result_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_reg <= res;
    end
  end

  assign status     = out_reg.status;
  assign hole_index = out_reg.hole_index;
  assign leftover   = out_reg.leftover;

endmodule

// ----- bench/best_fit_hole_allocator_tb.sv -----
// Self-checking testbench for the best-fit hole allocator.
`timescale 1ns / 1ps

module best_fit_hole_allocator_tb;
  import bfha_pkg::*;

  localparam logic [CMD_W-1:0] CMD_IDLE = 2'd3;
  localparam int ITEM_TARGET  = 1550;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 50;
  localparam int REPORT_MAX   = 10;

  // idling profiles for both sides
  localparam int IDLE_NONE  = 0;
  localparam int IDLE_LIGHT = 1;
  localparam int IDLE_HEAVY = 2;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    item_valid = 1'b0;
  logic                    item_stall;
  logic [CMD_W-1:0]        command = CMD_CLEAR;
  logic [SIZE_FIELD_W-1:0] size = '0;
  logic                    result_valid;
  logic                    result_stall = 1'b0;
  logic [STATUS_W-1:0]     status;
  logic [HOLE_INDEX_W-1:0] hole_index;
  logic [LEFTOVER_W-1:0]   leftover;

  // shadow table of the allocator
  logic [SIZE_BITS-1:0] hole_size_q [MAX_HOLES];
  logic                 hole_used_q [MAX_HOLES];
  int                   hole_count_q = 0;

  result_t outcome_q [$];
  result_t oldest_outcome;

  int sender_mode = IDLE_NONE;
  int stall_mode  = IDLE_NONE;
  int stall_left  = 0;
  int stall_len;
  int items_sent = 0;
  int rounds_run = 0;
  int results_checked = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int status_tally [4] = '{0, 0, 0, 0};

  best_fit_hole_allocator dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .command      (command),
    .size         (size),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .hole_index   (hole_index),
    .leftover     (leftover)
  );

  always #5 clk = ~clk;

  // Apply one command to the shadow table and return the result it causes.
  function automatic result_t compute_allocation(input logic [CMD_W-1:0] cmd,
                                                 input logic [SIZE_FIELD_W-1:0] req);
    result_t              res;
    logic [SIZE_BITS-1:0] need;
    logic [SIZE_BITS-1:0] best_left;
    int                   best;
    res = '0;
    res.status = ST_DONE;
    need = req[SIZE_BITS-1:0];
    best = -1;
    best_left = '0;
    case (cmd)
      CMD_CLEAR: begin
        hole_count_q = 0;
        for (int i = 0; i < MAX_HOLES; i++) hole_used_q[i] = 1'b0;
      end
      CMD_ADD: begin
        if (hole_count_q >= MAX_HOLES) begin
          res.status = ST_FULL;
        end else begin
          hole_size_q[hole_count_q] = need;
          hole_used_q[hole_count_q] = 1'b0;
          res.hole_index = HOLE_INDEX_W'(hole_count_q);
          hole_count_q++;
        end
      end
      CMD_REQUEST: begin
        // strict less-than keeps the lowest index on a tie
        for (int i = 0; i < hole_count_q; i++) begin
          if (!hole_used_q[i] && hole_size_q[i] >= need &&
              (best < 0 || hole_size_q[i] - need < best_left)) begin
            best = i;
            best_left = hole_size_q[i] - need;
          end
        end
        if (best < 0) begin
          res.status = ST_NO_FIT;
        end else begin
          hole_used_q[best] = 1'b1;
          res.status = ST_ALLOCATED;
          res.hole_index = HOLE_INDEX_W'(best);
          res.leftover = LEFTOVER_W'(best_left);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic int pick_gap(input int mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      IDLE_LIGHT: begin
        if (r < 80) return 0;
        if (r < 97) return $urandom_range(1, 3);
        return $urandom_range(8, 20);
      end
      IDLE_HEAVY: begin
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
      end
      default: return 0;
    endcase
  endfunction

  // Sizes near existing holes give exact fits, ties and near misses.
  function automatic logic [SIZE_FIELD_W-1:0] pick_size(input bit tiny);
    int                      r;
    logic [SIZE_FIELD_W-1:0] base;
    r = $urandom_range(0, 9);
    if (hole_count_q != 0 && r < 4) begin
      base = SIZE_FIELD_W'(hole_size_q[$urandom_range(0, hole_count_q - 1)]);
      case ($urandom_range(0, 2))
        0: if (base != '0) base = base - 1'b1;
        2: if (base != '1) base = base + 1'b1;
        default: ;
      endcase
      return base;
    end
    if (r == 4) return '0;
    if (r == 5 && !tiny) return '1;
    return tiny ? SIZE_FIELD_W'($urandom_range(0, 15)) : SIZE_FIELD_W'($urandom);
  endfunction

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [SIZE_FIELD_W-1:0] sz);
    int gap;
    gap = pick_gap(sender_mode);
    @(negedge clk);
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid = 1'b1;
    command = cmd;
    size = sz;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    outcome_q.push_back(compute_allocation(cmd, sz));
    if (cmd != CMD_IDLE) items_sent++;
  endtask

  // Hold off the sender until every pending result is out.
  task automatic wait_results_drained();
    @(negedge clk);
    item_valid = 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    sender_mode = IDLE_LIGHT;
    stall_mode = IDLE_LIGHT;
    send_item(CMD_CLEAR, 16'hFFFF);
    send_item(CMD_REQUEST, 16'h0000);  // empty table
    send_item(CMD_ADD, 16'h0000);
    send_item(CMD_ADD, 16'hFFFF);
    send_item(CMD_ADD, 16'd100);
    send_item(CMD_ADD, 16'd100);
    send_item(CMD_ADD, 16'h5555);
    send_item(CMD_ADD, 16'hAAAA);
    send_item(CMD_REQUEST, 16'd100);   // exact fit, lower of two equal holes
    send_item(CMD_REQUEST, 16'd100);   // the other one
    send_item(CMD_REQUEST, 16'h0000);  // zero request takes the zero hole
    send_item(CMD_REQUEST, 16'h0000);  // next smallest, full size left over
    send_item(CMD_REQUEST, 16'hFFFF);
    send_item(CMD_REQUEST, 16'd1);
    send_item(CMD_REQUEST, 16'd1);     // everything used
    send_item(CMD_IDLE, 16'hFFFF);
  endtask

  task automatic test_table_full();
    sender_mode = IDLE_NONE;
    stall_mode = IDLE_HEAVY;
    while (hole_count_q < MAX_HOLES) send_item(CMD_ADD, SIZE_FIELD_W'($urandom));
    send_item(CMD_ADD, 16'd7);         // overflow
    send_item(CMD_REQUEST, 16'd0);
    send_item(CMD_CLEAR, 16'h5555);
    send_item(CMD_REQUEST, 16'd0);     // empty after clear
    send_item(CMD_ADD, 16'd42);
    send_item(CMD_REQUEST, 16'd42);    // slot 0 reused, used mark cleared
  endtask

  task automatic test_random_rounds();
    int  holes;
    int  reqs;
    int  r;
    bit  tiny;
    while (items_sent < ITEM_TARGET) begin
      rounds_run++;
      sender_mode = $urandom_range(IDLE_NONE, IDLE_HEAVY);
      stall_mode = $urandom_range(IDLE_NONE, IDLE_HEAVY);
      tiny = ($urandom_range(0, 2) == 0);
      send_item(CMD_CLEAR, SIZE_FIELD_W'($urandom));
      holes = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_HOLES + 1, MAX_HOLES + 4)
                                          : $urandom_range(1, MAX_HOLES);
      repeat (holes) send_item(CMD_ADD, pick_size(tiny));
      reqs = $urandom_range(1, 20);
      repeat (reqs) begin
        r = $urandom_range(0, 19);
        if (r == 0) send_item(CMD_IDLE, SIZE_FIELD_W'($urandom));
        else if (r == 1) send_item(CMD_ADD, pick_size(tiny));
        else send_item(CMD_REQUEST, pick_size(tiny));
      end
      if ($urandom_range(0, 7) == 0) wait_results_drained();
    end
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      result_stall = 1'b1;
    end else begin
      stall_len = pick_gap(stall_mode);
      result_stall = (stall_len > 0);
      if (stall_len > 0) stall_left = stall_len - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      results_checked++;
      status_tally[status]++;
      if (outcome_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected result: status %0d index %0d leftover %0d",
                   status, hole_index, leftover);
      end else begin
        oldest_outcome = outcome_q.pop_front();
        if (status !== oldest_outcome.status || hole_index !== oldest_outcome.hole_index ||
            leftover !== oldest_outcome.leftover) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("mismatch at result %0d: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                     results_checked, oldest_outcome.status, oldest_outcome.hole_index,
                     oldest_outcome.leftover, status, hole_index, leftover);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count, outcome_q.size());
      $display("** best_fit_hole_allocator: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_cases();
    test_table_full();
    wait_results_drained();
    test_random_rounds();
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("ran %0d items (%0d random rounds), checked %0d results", items_sent, rounds_run,
             results_checked);
    $display("  done %0d, allocated %0d, no fit %0d, table full %0d, mismatches %0d",
             status_tally[ST_DONE], status_tally[ST_ALLOCATED], status_tally[ST_NO_FIT],
             status_tally[ST_FULL], mismatch_count);
    if (mismatch_count == 0 && outcome_q.size() == 0) begin
      $display("** best_fit_hole_allocator: PASSED **");
    end else begin
      $display("** best_fit_hole_allocator: FAILED **");
    end
    $finish;
  end

endmodule
